FILE: hdl/sccb_pkg.sv
// Shared types, codes and sequencer functions for the SCCB/I2C master core.
package sccb_pkg;

    // Bus primitive codes used by the command programs
    typedef enum logic [2:0] {
        OP_END   = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_ACKW  = 3'd3,
        OP_READ  = 3'd4,
        OP_MACK  = 3'd5,
        OP_MNAK  = 3'd6,
        OP_STOP  = 3'd7
    } t_op;

    // Command codes
    localparam logic [1:0] CMD_WIDE_WR = 2'd0;
    localparam logic [1:0] CMD_WIDE_RD = 2'd1;
    localparam logic [1:0] CMD_BYTE_WR = 2'd2;
    localparam logic [1:0] CMD_BYTE_RD = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_CAM_ADDR = 8'd0;
    localparam logic [7:0] CFG_POLL_LIM = 8'd1;

    localparam logic [7:0] CAM_ADDR_RST = 8'd66;
    localparam logic [7:0] POLL_LIM_RST = 8'd255;
    localparam logic [4:0] PROG_LEN     = 5'd16;

    // One tick on the input channel
    typedef struct packed {
        logic        request_valid;
        logic [1:0]  command;
        logic [7:0]  device;
        logic [7:0]  reg_addr;
        logic [15:0] write_value;
        logic        sda_in;
    } t_req;

    // One tick of line levels and status
    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        ack_missing;
    } t_res;

    // Configuration write transaction
    typedef struct packed {
        logic [7:0] index;
        logic [7:0] value;
    } t_cfg_wr;

    // Current configuration register values
    typedef struct packed {
        logic [7:0] cam_addr;
        logic [7:0] poll_lim;
    } t_cfg_regs;

    // Sequencer state
    typedef struct packed {
        logic [4:0]  phase;
        logic [1:0]  tick_in_bit;
        logic [2:0]  bit_index;
        logic [2:0]  byte_index;
        logic [7:0]  shift_byte;
        logic [7:0]  poll_count;
        logic [15:0] read_accum;
        logic        ack_flag;
        logic [1:0]  held_command;
        logic [7:0]  held_device;
        logic [7:0]  held_register;
        logic [15:0] held_value;
        logic [1:0]  line_levels;
    } t_seq_state;

    // Program step lookup per command
    function automatic t_op f_prog_op(logic [1:0] cmd, logic [3:0] idx);
        t_op op;
        op = OP_END;
        unique case (cmd)
            CMD_WIDE_WR: begin
                unique case (idx)
                    4'd0:                      op = OP_START;
                    4'd1, 4'd3, 4'd5, 4'd7:    op = OP_WRITE;
                    4'd2, 4'd4, 4'd6, 4'd8:    op = OP_ACKW;
                    4'd9:                      op = OP_STOP;
                    default:                   op = OP_END;
                endcase
            end
            CMD_WIDE_RD: begin
                unique case (idx)
                    4'd0, 4'd6:                op = OP_START;
                    4'd1, 4'd3, 4'd7:          op = OP_WRITE;
                    4'd2, 4'd4, 4'd8:          op = OP_ACKW;
                    4'd5, 4'd13:               op = OP_STOP;
                    4'd9, 4'd11:               op = OP_READ;
                    4'd10:                     op = OP_MACK;
                    4'd12:                     op = OP_MNAK;
                    default:                   op = OP_END;
                endcase
            end
            CMD_BYTE_WR: begin
                unique case (idx)
                    4'd0:                      op = OP_START;
                    4'd1, 4'd3, 4'd5:          op = OP_WRITE;
                    4'd2, 4'd4, 4'd6:          op = OP_ACKW;
                    4'd7:                      op = OP_STOP;
                    default:                   op = OP_END;
                endcase
            end
            default: begin
                unique case (idx)
                    4'd0, 4'd5:                op = OP_START;
                    4'd1, 4'd3, 4'd6:          op = OP_WRITE;
                    4'd2, 4'd4, 4'd7:          op = OP_ACKW;
                    4'd8:                      op = OP_READ;
                    4'd9:                      op = OP_MNAK;
                    4'd10:                     op = OP_STOP;
                    default:                   op = OP_END;
                endcase
            end
        endcase
        return op;
    endfunction

    // Op at the current program counter; idle reads as end
    function automatic t_op f_cur_op(t_seq_state s);
        logic [4:0] pm1;
        pm1 = s.phase - 5'd1;
        if (s.phase == 5'd0)
            return OP_END;
        return f_prog_op(s.held_command, pm1[3:0]);
    endfunction

    // Byte to send for the next write primitive
    function automatic logic [7:0] f_send_byte(t_seq_state s, logic [7:0] cam_addr);
        logic [7:0] cam;
        logic [7:0] dev;
        logic [1:0] k;
        logic [7:0] b;
        cam = cam_addr & 8'hFE;
        dev = s.held_device & 8'hFE;
        k   = s.byte_index[1:0];
        b   = 8'h00;
        unique case (s.held_command)
            CMD_WIDE_WR: b = (k == 2'd0) ? cam : (k == 2'd1) ? s.held_register :
                             (k == 2'd2) ? s.held_value[15:8] : s.held_value[7:0];
            CMD_WIDE_RD: b = (k == 2'd0) ? cam : (k == 2'd1) ? s.held_register :
                             (cam | 8'h01);
            CMD_BYTE_WR: b = (k == 2'd0) ? dev : (k == 2'd1) ? s.held_register :
                             s.held_value[7:0];
            default:     b = (k == 2'd0) ? dev : (k == 2'd1) ? s.held_register :
                             (dev | 8'h01);
        endcase
        return b;
    endfunction

    // Set up the counters for the primitive at the program counter
    function automatic t_seq_state f_enter(t_seq_state s, logic [7:0] cam_addr);
        t_seq_state v;
        t_op        op;
        v  = s;
        op = f_cur_op(s);
        v.bit_index   = 3'd0;
        v.poll_count  = 8'd0;
        v.tick_in_bit = (op == OP_READ) ? 2'd3 : 2'd0;
        if (op == OP_WRITE) begin
            v.shift_byte = f_send_byte(s, cam_addr);
            v.byte_index = s.byte_index + 3'd1;
        end else if (op == OP_READ) begin
            v.shift_byte = 8'h00;
        end
        return v;
    endfunction

endpackage

FILE: hdl/sccb_chan_if.sv
// Valid/ready channel interface carrying one payload type.
interface sccb_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/sccb_seq.sv
// Bus sequencer: state registers and one-tick step logic.
module sccb_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  sccb_pkg::t_req        i_item,
    input  sccb_pkg::t_cfg_regs   i_cfg,
    output sccb_pkg::t_res        o_res
);
    import sccb_pkg::*;

    t_seq_state r_st;
    t_seq_state n_st;

    // One tick of the bus program
    always_comb begin
        t_seq_state v;
        t_op        op;
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       fin;
        logic [7:0] lim;
        logic [4:0] nph;
        logic       b;

        v    = r_st;
        scl  = r_st.line_levels[1];
        sda  = r_st.line_levels[0];
        busy = 1'b0;
        done = 1'b0;
        fin  = 1'b0;
        lim  = (i_cfg.poll_lim == 8'd0) ? 8'd1 : i_cfg.poll_lim;
        nph  = 5'd0;
        b    = 1'b0;
        op   = OP_END;

        // take a new request only when idle
        if (v.phase == 5'd0 && i_item.request_valid) begin
            v.held_command  = i_item.command;
            v.held_device   = i_item.device;
            v.held_register = i_item.reg_addr;
            v.held_value    = i_item.write_value;
            v.read_accum    = 16'h0000;
            v.ack_flag      = 1'b0;
            v.byte_index    = 3'd0;
            v.phase         = 5'd1;
            v = f_enter(v, i_cfg.cam_addr);
        end

        if (v.phase != 5'd0) begin
            op   = f_cur_op(v);
            busy = 1'b1;
            b    = v.shift_byte[7];
            unique case (op)
                OP_START: begin
                    scl = 1'b1;
                    sda = (v.tick_in_bit == 2'd0);
                    if (v.tick_in_bit == 2'd0) v.tick_in_bit = 2'd1;
                    else fin = 1'b1;
                end
                OP_WRITE: begin
                    unique case (v.tick_in_bit)
                        2'd3: begin scl = 1'b0; sda = 1'b1; fin = 1'b1; end
                        2'd0: begin scl = 1'b0; v.tick_in_bit = 2'd1; end
                        2'd1: begin scl = 1'b0; sda = b; v.tick_in_bit = 2'd2; end
                        default: begin
                            scl = 1'b1;
                            sda = b;
                            v.shift_byte = {v.shift_byte[6:0], 1'b0};
                            if (v.bit_index == 3'd7) v.tick_in_bit = 2'd3;
                            else begin
                                v.bit_index   = v.bit_index + 3'd1;
                                v.tick_in_bit = 2'd0;
                            end
                        end
                    endcase
                end
                OP_ACKW: begin
                    sda = 1'b1;
                    unique case (v.tick_in_bit)
                        2'd0: begin scl = 1'b0; v.tick_in_bit = 2'd1; end
                        2'd1: begin scl = 1'b1; v.tick_in_bit = 2'd2; end
                        2'd2: begin
                            scl = 1'b1;
                            if (!i_item.sda_in) v.tick_in_bit = 2'd3;
                            else begin
                                v.poll_count = v.poll_count + 8'd1;
                                if (v.poll_count >= lim) begin
                                    v.ack_flag    = 1'b1;
                                    v.tick_in_bit = 2'd3;
                                end
                            end
                        end
                        default: begin scl = 1'b0; fin = 1'b1; end
                    endcase
                end
                OP_READ: begin
                    sda = 1'b1;
                    unique case (v.tick_in_bit)
                        2'd3: begin scl = 1'b0; v.tick_in_bit = 2'd0; end
                        2'd0: begin scl = 1'b1; v.tick_in_bit = 2'd1; end
                        2'd1: begin
                            scl = 1'b1;
                            v.shift_byte  = {v.shift_byte[6:0], i_item.sda_in};
                            v.tick_in_bit = 2'd2;
                        end
                        default: begin
                            scl = 1'b0;
                            if (v.bit_index == 3'd7) begin
                                v.read_accum = {v.read_accum[7:0], v.shift_byte};
                                fin = 1'b1;
                            end else begin
                                v.bit_index   = v.bit_index + 3'd1;
                                v.tick_in_bit = 2'd0;
                            end
                        end
                    endcase
                end
                OP_MACK, OP_MNAK: begin
                    sda = (op == OP_MNAK);
                    scl = (v.tick_in_bit == 2'd1);
                    if (v.tick_in_bit >= 2'd2) fin = 1'b1;
                    else v.tick_in_bit = v.tick_in_bit + 2'd1;
                end
                OP_STOP: begin
                    unique case (v.tick_in_bit)
                        2'd0: begin scl = 1'b0; sda = 1'b0; v.tick_in_bit = 2'd1; end
                        2'd1: begin scl = 1'b1; sda = 1'b0; v.tick_in_bit = 2'd2; end
                        default: begin scl = 1'b1; sda = 1'b1; fin = 1'b1; end
                    endcase
                end
                default: fin = 1'b1;
            endcase

            // advance the program counter, finish at end of program
            if (fin) begin
                nph     = v.phase + 5'd1;
                v.phase = nph;
                if (nph > PROG_LEN || f_cur_op(v) == OP_END) begin
                    v.phase = 5'd0;
                    done    = 1'b1;
                end else begin
                    v = f_enter(v, i_cfg.cam_addr);
                end
            end
        end

        v.line_levels     = {scl, sda};
        n_st              = v;
        o_res.scl_level   = scl;
        o_res.sda_level   = sda;
        o_res.busy_res    = busy;
        o_res.done_res    = done;
        o_res.read_value  = (done && v.held_command[0]) ? v.read_accum : 16'h0000;
        o_res.ack_missing = v.ack_flag;
    end

    // State update on each accepted tick; both lines released after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{line_levels: 2'b11, default: '0};
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule

FILE: hdl/sccb_out_stage.sv
// Result register between the sequencer and the output channel.
module sccb_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  sccb_pkg::t_res  i_res,
    input  logic            i_ready,
    output logic            o_free,
    output logic            o_valid,
    output sccb_pkg::t_res  o_res
);
    import sccb_pkg::*;

    logic r_valid;
    t_res r_res;

    // Room for a new result when empty or draining this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: hdl/sccb_i2c_master_core.sv
// Top level of the SCCB/I2C bit-banged bus master core.
//
// i_req carries one bus delay tick per transfer: the sampled data line and,
// while idle, an optional command (wide write, wide read, byte write, byte
// read). For every accepted tick exactly one result appears on o_res with the
// clock and data line levels to drive, busy, done on the stop tick, the read
// data on that tick and the acknowledge-missing flag.
// The result of each accepted tick is registered in the output stage; one tick
// is accepted every cycle while the output register has room for it.
// i_cfg writes the camera device address (index 0) and the acknowledge poll
// limit (index 1); it is always ready and should be written while idle.
// Reset (synchronous, active low) returns the sequencer to idle with both
// lines released high and the registers to address 66 and limit 255.
// When the receiver stalls, the pending result holds in the output register
// and i_req.ready drops until it is taken; no tick is lost or repeated.
module sccb_i2c_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sccb_chan_if.sink   i_req,
    sccb_chan_if.sink   i_cfg,
    sccb_chan_if.source o_res
);
    import sccb_pkg::*;

    t_cfg_regs r_cfg;
    t_res      w_step_res;
    t_res      w_out_res;
    logic      w_free;
    logic      w_step;
    logic      w_out_valid;
    t_cfg_wr   w_cfg_wr;
    t_req      w_item;

    assign w_cfg_wr    = i_cfg.data;
    assign w_item      = i_req.data;
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_free;
    assign w_step      = i_req.valid && w_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_addr <= CAM_ADDR_RST;
            r_cfg.poll_lim <= POLL_LIM_RST;
        end else if (i_cfg.valid) begin
            if (w_cfg_wr.index == CFG_CAM_ADDR) r_cfg.cam_addr <= w_cfg_wr.value;
            if (w_cfg_wr.index == CFG_POLL_LIM) r_cfg.poll_lim <= w_cfg_wr.value;
        end
    end

    sccb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_res   (w_step_res)
    );

    sccb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_res   (w_step_res),
        .i_ready (o_res.ready),
        .o_free  (w_free),
        .o_valid (w_out_valid),
        .o_res   (w_out_res)
    );

    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_out_res;

endmodule

FILE: hdl/sccb_checker.sv
// Port-level checker for the SCCB/I2C master core, bound to the top level.
module sccb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input sccb_pkg::t_res i_out
);
    import sccb_pkg::*;

    // Every accepted tick leaves a result in the output register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted tick produced no result");

    // A stalled result holds until it is taken
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out)))
        else $error("stalled result changed");

    // Stop completion is reported only inside a running transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out.done_res) |-> i_out.busy_res)
        else $error("done without busy");

    // Read data is shown only on the done tick
    a_read_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out.read_value != 16'h0000)) |-> i_out.done_res)
        else $error("read data outside done tick");

    // An idle result with the clock line low is never flagged done
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out.busy_res && i_out.ack_missing == 1'b0 &&
         !i_out.scl_level) |-> !i_out.done_res)
        else $error("idle result flagged done");

endmodule

bind sccb_i2c_master_core sccb_checker u_sccb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out       (o_res.data)
);
